>>> design/ign3_pkg.sv
// Shared constants for the 3D gradient noise pipeline: default fraction width,
// output format and the 256-entry permutation table.
// No dependencies.
package ign3_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 24;
    localparam int OUT_FRAC      = 16;
    localparam int OUT_W         = 19;
    localparam int OUT_MIN       = -262144;
    localparam int OUT_MAX       = 262143;

    localparam logic [7:0] PERM_TABLE [0:255] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    typedef logic [3:0] hash_t;

endpackage

>>> design/ign3_fade.sv
// Three-stage quintic fade curve 6t^5 - 15t^4 + 10t^3 for one coordinate.
// Depends on ign3_pkg.
module ign3_fade #(
    parameter int FRAC_BITS = ign3_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [FRAC_BITS-1:0] t_in,
    output logic [FRAC_BITS:0]   fade_out
);
    localparam int F  = FRAC_BITS;
    localparam int VW = F + 6;
    localparam int PW = 2 * VW;
    localparam logic signed [VW-1:0] C15  = VW'(15 * (2 ** F));
    localparam logic signed [VW-1:0] C10  = VW'(10 * (2 ** F));
    localparam logic signed [VW-1:0] ONE  = VW'(2 ** F);
    localparam logic signed [PW-1:0] HALF = PW'(2 ** (F - 1));

    logic signed [VW-1:0] t_ext, s;
    logic signed [PW-1:0] p_ts, p_tt, p_t3, p_f, r_ts, r_tt, r_t3, r_f;
    logic signed [VW-1:0] f_raw;

    logic signed [VW-1:0] t_a_reg, ts_a_reg, t2_a_reg;
    logic signed [VW-1:0] k_b_reg, t3_b_reg;
    logic [F:0]           f_c_reg;

    always_comb begin
        t_ext = VW'({6'd0, t_in});
        s     = (t_ext <<< 2) + (t_ext <<< 1) - C15;
        p_ts  = t_ext * s;
        p_tt  = t_ext * t_ext;
        r_ts  = (p_ts + HALF) >>> F;
        r_tt  = (p_tt + HALF) >>> F;
        p_t3  = t2_a_reg * t_a_reg;
        r_t3  = (p_t3 + HALF) >>> F;
        p_f   = t3_b_reg * k_b_reg;
        r_f   = (p_f + HALF) >>> F;
        f_raw = r_f[VW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_a_reg  <= t_ext;
            ts_a_reg <= r_ts[VW-1:0];
            t2_a_reg <= r_tt[VW-1:0];
            k_b_reg  <= ts_a_reg + C10;
            t3_b_reg <= r_t3[VW-1:0];
            if (f_raw < 0)
                f_c_reg <= '0;
            else if (f_raw > ONE)
                f_c_reg <= ONE[F:0];
            else
                f_c_reg <= f_raw[F:0];
        end
    end

    assign fade_out = f_c_reg;

endmodule

>>> design/ign3_hash.sv
// Three-stage permutation hash: corner hashes for the eight cube corners,
// with the fractions carried alongside. Depends on ign3_pkg.
module ign3_hash #(
    parameter int FRAC_BITS = ign3_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [7:0]           ix,
    input  logic [7:0]           iy,
    input  logic [7:0]           iz,
    input  logic [FRAC_BITS-1:0] fx_in,
    input  logic [FRAC_BITS-1:0] fy_in,
    input  logic [FRAC_BITS-1:0] fz_in,
    output ign3_pkg::hash_t      hash_out [8],
    output logic [FRAC_BITS-1:0] fx_out,
    output logic [FRAC_BITS-1:0] fy_out,
    output logic [FRAC_BITS-1:0] fz_out
);
    import ign3_pkg::*;

    logic [8:0]           a_reg, b_reg;
    logic [7:0]           iz1_reg;
    logic [8:0]           aa_reg, ab_reg, ba_reg, bb_reg;
    hash_t                h_reg [8];
    logic [FRAC_BITS-1:0] fx_reg [3];
    logic [FRAC_BITS-1:0] fy_reg [3];
    logic [FRAC_BITS-1:0] fz_reg [3];
    logic [7:0]           ix_p1, a_p1, b_p1;
    logic [7:0]           aa_p1, ab_p1, ba_p1, bb_p1;
    logic [7:0]           p_aa, p_ba, p_ab, p_bb, p_aa1, p_ba1, p_ab1, p_bb1;

    always_comb begin
        ix_p1 = ix + 8'd1;
        a_p1  = a_reg[7:0] + 8'd1;
        b_p1  = b_reg[7:0] + 8'd1;
        aa_p1 = aa_reg[7:0] + 8'd1;
        ab_p1 = ab_reg[7:0] + 8'd1;
        ba_p1 = ba_reg[7:0] + 8'd1;
        bb_p1 = bb_reg[7:0] + 8'd1;
        p_aa  = PERM_TABLE[aa_reg[7:0]];
        p_ba  = PERM_TABLE[ba_reg[7:0]];
        p_ab  = PERM_TABLE[ab_reg[7:0]];
        p_bb  = PERM_TABLE[bb_reg[7:0]];
        p_aa1 = PERM_TABLE[aa_p1];
        p_ba1 = PERM_TABLE[ba_p1];
        p_ab1 = PERM_TABLE[ab_p1];
        p_bb1 = PERM_TABLE[bb_p1];
    end

    // corner order: bit 0 = x+1, bit 1 = y+1, bit 2 = z+1
    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg     <= {1'b0, PERM_TABLE[ix]} + {1'b0, iy};
            b_reg     <= {1'b0, PERM_TABLE[ix_p1]} + {1'b0, iy};
            iz1_reg   <= iz;
            aa_reg    <= {1'b0, PERM_TABLE[a_reg[7:0]]} + {1'b0, iz1_reg};
            ab_reg    <= {1'b0, PERM_TABLE[a_p1]} + {1'b0, iz1_reg};
            ba_reg    <= {1'b0, PERM_TABLE[b_reg[7:0]]} + {1'b0, iz1_reg};
            bb_reg    <= {1'b0, PERM_TABLE[b_p1]} + {1'b0, iz1_reg};
            h_reg[0]  <= p_aa[3:0];
            h_reg[1]  <= p_ba[3:0];
            h_reg[2]  <= p_ab[3:0];
            h_reg[3]  <= p_bb[3:0];
            h_reg[4]  <= p_aa1[3:0];
            h_reg[5]  <= p_ba1[3:0];
            h_reg[6]  <= p_ab1[3:0];
            h_reg[7]  <= p_bb1[3:0];
            fx_reg[0] <= fx_in;
            fy_reg[0] <= fy_in;
            fz_reg[0] <= fz_in;
            for (int i = 1; i < 3; i++) begin
                fx_reg[i] <= fx_reg[i-1];
                fy_reg[i] <= fy_reg[i-1];
                fz_reg[i] <= fz_reg[i-1];
            end
        end
    end

    assign hash_out = h_reg;
    assign fx_out   = fx_reg[2];
    assign fy_out   = fy_reg[2];
    assign fz_out   = fz_reg[2];

endmodule

>>> design/ign3_blend.sv
// Gradient evaluation and the three interpolation levels (x, y, z), then
// output scaling and saturation. Five stages. Depends on ign3_pkg.
module ign3_blend #(
    parameter int FRAC_BITS = ign3_pkg::FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       en,
    input  ign3_pkg::hash_t            hash_in [8],
    input  logic [FRAC_BITS-1:0]       fx,
    input  logic [FRAC_BITS-1:0]       fy,
    input  logic [FRAC_BITS-1:0]       fz,
    input  logic [FRAC_BITS:0]         fade_u,
    input  logic [FRAC_BITS:0]         fade_v,
    input  logic [FRAC_BITS:0]         fade_w,
    output logic [ign3_pkg::OUT_W-1:0] noise_out
);
    import ign3_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int LW = F + 5;
    localparam int PW = 2 * LW;
    localparam int RW = LW + OUT_FRAC + 1;
    localparam logic signed [LW-1:0] ONE  = LW'(2 ** F);
    localparam logic signed [PW-1:0] HALF = PW'(2 ** (F - 1));
    localparam logic signed [RW-1:0] OMIN = RW'(OUT_MIN);
    localparam logic signed [RW-1:0] OMAX = RW'(OUT_MAX);

    logic signed [LW-1:0] gx [2], gy [2], gz [2];
    logic signed [LW-1:0] g_next [8];
    logic signed [LW-1:0] g_reg [8];
    logic signed [LW-1:0] u4_reg, v4_reg, w4_reg, v5_reg, w5_reg, w6_reg;
    logic signed [LW-1:0] a5_reg [4];
    logic signed [PW-1:0] p5_reg [4];
    logic signed [LW-1:0] a6_reg [2];
    logic signed [PW-1:0] p6_reg [2];
    logic signed [LW-1:0] a7_reg;
    logic signed [PW-1:0] p7_reg;
    logic [OUT_W-1:0]     out_reg;

    logic signed [PW-1:0] r5 [4], r6 [2], r7;
    logic signed [LW-1:0] l1 [4], l2 [2], lz;
    logic signed [RW-1:0] r_ext, r_scaled, r_sat;

    always_comb begin
        gx[0] = LW'({5'd0, fx});
        gy[0] = LW'({5'd0, fy});
        gz[0] = LW'({5'd0, fz});
        gx[1] = gx[0] - ONE;
        gy[1] = gy[0] - ONE;
        gz[1] = gz[0] - ONE;
        for (int c = 0; c < 8; c++) begin
            logic signed [LW-1:0] cu, cv, cx, cy, cz;
            logic [3:0]           h;
            h  = hash_in[c];
            cx = gx[c % 2];
            cy = gy[(c / 2) % 2];
            cz = gz[c / 4];
            cu = (h < 4'd8) ? cx : cy;
            cv = (h < 4'd4) ? cy : ((h == 4'd12 || h == 4'd14) ? cx : cz);
            g_next[c] = (h[0] ? -cu : cu) + (h[1] ? -cv : cv);
        end
        for (int k = 0; k < 4; k++) begin
            r5[k] = (p5_reg[k] + HALF) >>> F;
            l1[k] = a5_reg[k] + r5[k][LW-1:0];
        end
        for (int j = 0; j < 2; j++) begin
            r6[j] = (p6_reg[j] + HALF) >>> F;
            l2[j] = a6_reg[j] + r6[j][LW-1:0];
        end
        r7    = (p7_reg + HALF) >>> F;
        lz    = a7_reg + r7[LW-1:0];
        r_ext = RW'(lz);
    end

    generate
        if (F > OUT_FRAC) begin : g_down
            localparam logic signed [RW-1:0] RHALF = RW'(2 ** (F - OUT_FRAC - 1));
            assign r_scaled = (r_ext + RHALF) >>> (F - OUT_FRAC);
        end else if (F < OUT_FRAC) begin : g_up
            assign r_scaled = r_ext <<< (OUT_FRAC - F);
        end else begin : g_same
            assign r_scaled = r_ext;
        end
    endgenerate

    always_comb begin
        if (r_scaled < OMIN)
            r_sat = OMIN;
        else if (r_scaled > OMAX)
            r_sat = OMAX;
        else
            r_sat = r_scaled;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_reg  <= g_next;
            u4_reg <= LW'({4'd0, fade_u});
            v4_reg <= LW'({4'd0, fade_v});
            w4_reg <= LW'({4'd0, fade_w});
            // x lerps
            for (int k = 0; k < 4; k++) begin
                a5_reg[k] <= g_reg[2*k];
                p5_reg[k] <= u4_reg * (g_reg[2*k+1] - g_reg[2*k]);
            end
            v5_reg <= v4_reg;
            w5_reg <= w4_reg;
            // y lerps
            for (int j = 0; j < 2; j++) begin
                a6_reg[j] <= l1[2*j];
                p6_reg[j] <= v5_reg * (l1[2*j+1] - l1[2*j]);
            end
            w6_reg <= w5_reg;
            // z lerp
            a7_reg  <= l2[0];
            p7_reg  <= w6_reg * (l2[1] - l2[0]);
            out_reg <= r_sat[OUT_W-1:0];
        end
    end

    assign noise_out = out_reg;

endmodule

>>> design/improved_gradient_noise_3d.sv
// Improved 3D gradient noise, fixed point. One word in per clock, one word out
// per clock while the output is not stalled; the pipeline is made of the
// fade multiplier chain and hash lookups (3 stages) and the gradient and three
// lerp levels (5 stages). The whole pipeline holds when m_tvalid is high and
// m_tready is low, so s_tready follows that condition. Coordinates are
// unsigned with FRAC_BITS fraction bits, integer part wrapping modulo 256;
// the result has 16 fraction bits and saturates to 19 signed bits.
// Depends on ign3_pkg, ign3_fade, ign3_hash, ign3_blend.
module improved_gradient_noise_3d #(
    parameter int FRAC_BITS = ign3_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // coord_x [23:0], coord_y [47:24], coord_z [71:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // noise_value [18:0], zero pad [23:19]
);
    import ign3_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int STAGES = 8;

    logic [COORD_W-1:0] cx, cy, cz;
    logic [COORD_W+7:0] cx_w, cy_w, cz_w;
    logic [7:0]         ix, iy, iz;
    logic               en;
    logic [STAGES-1:0]  vld_reg, vld_next;
    logic [F:0]         fu, fv, fw;
    hash_t              hashes [8];
    logic [F-1:0]       hx, hy, hz;
    logic [OUT_W-1:0]   noise;

    assign cx   = s_tdata[COORD_W-1:0];
    assign cy   = s_tdata[2*COORD_W-1:COORD_W];
    assign cz   = s_tdata[3*COORD_W-1:2*COORD_W];
    assign cx_w = {8'd0, cx} >> F;
    assign cy_w = {8'd0, cy} >> F;
    assign cz_w = {8'd0, cz} >> F;
    assign ix   = cx_w[7:0];
    assign iy   = cy_w[7:0];
    assign iz   = cz_w[7:0];

    assign en       = !(vld_reg[STAGES-1] && !m_tready);
    assign s_tready = en;
    assign vld_next = {vld_reg[STAGES-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    ign3_fade #(.FRAC_BITS(F)) u_fade_x (.aclk(aclk), .en(en), .t_in(cx[F-1:0]), .fade_out(fu));
    ign3_fade #(.FRAC_BITS(F)) u_fade_y (.aclk(aclk), .en(en), .t_in(cy[F-1:0]), .fade_out(fv));
    ign3_fade #(.FRAC_BITS(F)) u_fade_z (.aclk(aclk), .en(en), .t_in(cz[F-1:0]), .fade_out(fw));

    ign3_hash #(.FRAC_BITS(F)) u_hash (
        .aclk     (aclk),
        .en       (en),
        .ix       (ix),
        .iy       (iy),
        .iz       (iz),
        .fx_in    (cx[F-1:0]),
        .fy_in    (cy[F-1:0]),
        .fz_in    (cz[F-1:0]),
        .hash_out (hashes),
        .fx_out   (hx),
        .fy_out   (hy),
        .fz_out   (hz)
    );

    ign3_blend #(.FRAC_BITS(F)) u_blend (
        .aclk      (aclk),
        .en        (en),
        .hash_in   (hashes),
        .fx        (hx),
        .fy        (hy),
        .fz        (hz),
        .fade_u    (fu),
        .fade_v    (fv),
        .fade_w    (fw),
        .noise_out (noise)
    );

    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata  = {5'd0, noise};

endmodule

>>> sim/ign3_checker.sv
// Result checker for the 3D gradient noise block: watches both stream channels,
// predicts each noise word in fixed point and compares it with the output word.
// Depends on ign3_pkg.
`timescale 1ns / 100ps

module ign3_checker #(
    parameter int FRAC_BITS = ign3_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    import ign3_pkg::*;

    logic signed [OUT_W-1:0] noise_queue[$];

    function automatic longint rnd_shift(longint p, int n);
        return (p + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return rnd_shift(a * b, FRAC_BITS);
    endfunction

    function automatic longint fade_curve(longint t);
        longint one, k, t2, t3, f;
        one = longint'(1) <<< FRAC_BITS;
        k   = qmul(t, 6 * t - 15 * one) + 10 * one;
        t2  = qmul(t, t);
        t3  = qmul(t2, t);
        f   = qmul(t3, k);
        if (f < 0) f = 0;
        if (f > one) f = one;
        return f;
    endfunction

    function automatic longint blend(longint t, longint a, longint b);
        return a + qmul(t, b - a);
    endfunction

    function automatic longint corner_grad(int h8, longint x, longint y, longint z);
        hash_t  h;
        longint u, v;
        h = hash_t'(h8);
        u = (h < 8) ? x : y;
        v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic int perm(int i);
        return int'(PERM_TABLE[i & 255]);
    endfunction

    function automatic logic signed [OUT_W-1:0] noise_at(logic [71:0] word);
        longint one, x, y, z, x1, y1, z1, u, v, w, r;
        int ix, iy, iz, a, aa, ab, b, ba, bb;
        logic [COORD_W-1:0] cx, cy, cz;
        one = longint'(1) <<< FRAC_BITS;
        cx = word[23:0];
        cy = word[47:24];
        cz = word[71:48];
        ix = int'(cx >> FRAC_BITS) & 255;
        iy = int'(cy >> FRAC_BITS) & 255;
        iz = int'(cz >> FRAC_BITS) & 255;
        x = cx & ((1 << FRAC_BITS) - 1);
        y = cy & ((1 << FRAC_BITS) - 1);
        z = cz & ((1 << FRAC_BITS) - 1);
        u = fade_curve(x);
        v = fade_curve(y);
        w = fade_curve(z);
        a  = perm(ix) + iy;
        aa = perm(a) + iz;
        ab = perm(a + 1) + iz;
        b  = perm(ix + 1) + iy;
        ba = perm(b) + iz;
        bb = perm(b + 1) + iz;
        x1 = x - one;
        y1 = y - one;
        z1 = z - one;
        r = blend(w,
            blend(v, blend(u, corner_grad(perm(aa), x, y, z),
                              corner_grad(perm(ba), x1, y, z)),
                     blend(u, corner_grad(perm(ab), x, y1, z),
                              corner_grad(perm(bb), x1, y1, z))),
            blend(v, blend(u, corner_grad(perm(aa + 1), x, y, z1),
                              corner_grad(perm(ba + 1), x1, y, z1)),
                     blend(u, corner_grad(perm(ab + 1), x, y1, z1),
                              corner_grad(perm(bb + 1), x1, y1, z1))));
        if (FRAC_BITS > OUT_FRAC)
            r = rnd_shift(r, FRAC_BITS - OUT_FRAC);
        else if (FRAC_BITS < OUT_FRAC)
            r = r <<< (OUT_FRAC - FRAC_BITS);
        if (r < OUT_MIN) r = OUT_MIN;
        if (r > OUT_MAX) r = OUT_MAX;
        return r[OUT_W-1:0];
    endfunction

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        logic signed [OUT_W-1:0] want;
        if (aresetn && s_tvalid && s_tready)
            noise_queue.push_back(noise_at(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            if (noise_queue.size() == 0) begin
                $error("unexpected output word noise_value=%0d",
                       $signed(m_tdata[OUT_W-1:0]));
                fail_count++;
            end else begin
                want = noise_queue.pop_front();
                if (m_tdata[OUT_W-1:0] !== want) begin
                    $error("noise_value mismatch: expected %0d, actual %0d",
                           want, $signed(m_tdata[OUT_W-1:0]));
                    fail_count++;
                end
                if (m_tdata[23:OUT_W] !== '0) begin
                    $error("pad mismatch: expected 0, actual %0h", m_tdata[23:OUT_W]);
                    fail_count++;
                end
            end
        end
        pending = noise_queue.size();
    end
endmodule

>>> sim/tb_improved_gradient_noise_3d.sv
// Testbench top for improved_gradient_noise_3d: drives coordinate words with
// random idling and stalls, and reports the verdict from ign3_checker.
// Depends on ign3_pkg, ign3_checker and the block under test.
`timescale 1ns / 100ps

module tb_improved_gradient_noise_3d;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    int          fail_count, pending;
    int          send_idle = 0, recv_stall = 0;
    bit          hold_off = 0;

    improved_gradient_noise_3d DUT (.*);
    ign3_checker watcher (.*);

    initial forever #5 aclk = ~aclk;

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(negedge aclk) begin
        if (hold_off) begin
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // valid stays high into the next word unless the sender idles
    task automatic send_word(logic [23:0] cx, logic [23:0] cy, logic [23:0] cz);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {cz, cy, cx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(5))
            0: return 24'hFFFFFF;
            1: return {8'($urandom_range(255)), 16'h0000};
            2: return {8'($urandom_range(255)), 16'hFFFF};
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        int stalls[4] = '{0, 0, 62, 35};
        int idles[4]  = '{0, 62, 0, 35};
        logic [23:0] edges[6] = '{24'h000000, 24'hFFFFFF, 24'h008000, 24'h010000,
                                  24'hFF0000, 24'h00FFFF};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // corners and fraction extremes
        foreach (edges[i]) send_word(edges[i], edges[(i + 1) % 6], edges[(i + 3) % 6]);
        for (int i = 0; i < 16; i++)
            send_word({i[7:0], 16'h4000}, {8'(i * 17), 16'hC000}, {8'(255 - i), 16'h8000});
        // long hold-off so the pipeline fills and stalls its input
        hold_off = 1;
        fork
            begin
                int cnt = 0;
                while (cnt < 60) begin
                    @(posedge aclk);
                    cnt++;
                end
                hold_off = 0;
            end
            for (int i = 0; i < 30; i++) send_word(rand_coord(), rand_coord(), rand_coord());
        join
        for (int p = 0; p < 4; p++) begin
            send_idle  = idles[p];
            recv_stall = stalls[p];
            for (int i = 0; i < 300; i++) send_word(rand_coord(), rand_coord(), rand_coord());
        end
        s_tvalid <= 0;
        send_idle = 0;
        recv_stall = 0;
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> improved_gradient_noise_3d.f
design/ign3_pkg.sv
design/ign3_fade.sv
design/ign3_hash.sv
design/ign3_blend.sv
design/improved_gradient_noise_3d.sv
sim/ign3_checker.sv
sim/tb_improved_gradient_noise_3d.sv
